[hdl/wav_header_parser_stream_defines.svh]
// Assertion macros for the WAV header parser.
`ifndef WAV_HEADER_PARSER_STREAM_DEFINES_SVH
`define WAV_HEADER_PARSER_STREAM_DEFINES_SVH

`ifndef SYNTHESIS
`define WAVP_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("wavp: assertion failed");
`define WAVP_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("wavp: assertion failed");
`else
`define WAVP_ASSERT(lbl, prop)
`define WAVP_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[hdl/wavp_pkg.sv]
`default_nettype none

package wavp_pkg;

   typedef enum logic [2:0] {
      PH_RIFF = 3'd0,
      PH_HDR  = 3'd1,
      PH_FMT  = 3'd2,
      PH_SKIP = 3'd3,
      PH_PAY  = 3'd4,
      PH_DONE = 3'd5
   } phase_type;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_SHORT       = 3'd1,
      ST_BAD_TAG     = 3'd2,
      ST_NO_DATA     = 3'd3,
      ST_NO_FMT      = 3'd4,
      ST_UNSUPPORTED = 3'd5
   } status_type;

   localparam logic [31:0] TAG_RIFF = 32'h52494646;
   localparam logic [31:0] TAG_WAVE = 32'h57415645;
   localparam logic [31:0] TAG_FMT  = 32'h666D7420;
   localparam logic [31:0] TAG_DATA = 32'h64617461;

   localparam logic [31:0] FMT_BODY_LEN = 32'd16;
   localparam logic [15:0] PCM_FORMAT   = 16'd1;
   localparam logic [15:0] PCM_BITS     = 16'd16;

   // Character of a tag at text position pos (0 is the first character).
   function automatic logic [7:0] tag_char(logic [31:0] tag, logic [1:0] pos);
      return 8'(tag >> {~pos, 3'b000});
   endfunction

   // Replace byte pos of a little-endian word.
   function automatic logic [31:0] put_byte(logic [31:0] v, logic [1:0] pos,
                                            logic [7:0] b);
      logic [31:0] mask;
      mask = 32'h0000_00FF << {pos, 3'b000};
      return (v & ~mask) | ({24'h0, b} << {pos, 3'b000});
   endfunction

endpackage

`default_nettype wire

[hdl/wav_header_parser_stream.sv]
// Channel  Direction  Handshake              Payload
// req      in         req_valid / req_ready  file byte, first, last, abort marks
// rsp      out        rsp_valid / rsp_ready  header status and fmt fields or a data byte
//
// One byte is taken per cycle while req_ready is high; the parse state updates in the
// same cycle the byte is accepted and a result appears in the output register in the
// cycle after. The output register is the only stage: req_ready stays high while it is
// empty or being drained, so back-to-back bytes flow at one per clock.
// Synchronous reset clears the parser to wait for the RIFF tag and empties the
// output register.
`default_nettype none
`include "wav_header_parser_stream_defines.svh"

module wav_header_parser_stream (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_file_byte,
   input  wire logic        req_first_of_file,
   input  wire logic        req_last_of_file,
   input  wire logic        req_abort,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_is_payload,
   output logic [2:0]       rsp_status,
   output logic [15:0]      rsp_format_code,
   output logic [15:0]      rsp_channels,
   output logic [31:0]      rsp_sample_hz,
   output logic [15:0]      rsp_sample_bits,
   output logic [31:0]      rsp_chunk_bytes,
   output logic [7:0]       rsp_payload_byte,
   output logic             rsp_final_res
);

   // parser state
   wavp_pkg::phase_type phase_ff, phase_in, cur_phase;
   logic [3:0]  byte_index_ff, byte_index_in, cur_index;
   logic [31:0] chunk_tag_ff, chunk_tag_in, cur_tag;
   logic [31:0] chunk_length_ff, chunk_length_in, cur_length;
   logic [32:0] skip_count_ff, skip_count_in, cur_skip;
   logic        tag_ok_ff, tag_ok_in, cur_tag_ok;
   logic        fmt_seen_ff, fmt_seen_in, cur_fmt_seen;
   logic [15:0] format_tag_ff, format_tag_in, cur_format;
   logic [15:0] channel_count_ff, channel_count_in, cur_channels;
   logic [31:0] rate_value_ff, rate_value_in, cur_rate;
   logic [15:0] depth_value_ff, depth_value_in, cur_depth;
   logic [31:0] remaining_ff, remaining_in, cur_remaining;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic        is_payload_ff, is_payload_in;
   wavp_pkg::status_type status_ff, status_in;
   logic [15:0] format_code_ff, format_code_in;
   logic [15:0] channels_ff, channels_in;
   logic [31:0] sample_hz_ff, sample_hz_in;
   logic [15:0] bits_ff, bits_in;
   logic [31:0] chunk_bytes_ff, chunk_bytes_in;
   logic [7:0]  payload_byte_ff, payload_byte_in;
   logic        final_ff, final_in;

   logic        req_fire;
   logic        end_check;
   logic        res_valid;
   logic        hdr_emit;
   wavp_pkg::status_type hdr_status;
   logic [31:0] hdr_dsize;
   logic        hdr_final;
   logic        pay_emit;
   logic        pay_final;
   logic [7:0]  b;
   logic [1:0]  pos;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign b         = req_file_byte;

   // A start mark clears everything before the byte is parsed.
   always_comb begin
      if (req_first_of_file) begin
         cur_phase     = wavp_pkg::PH_RIFF;
         cur_index     = '0;
         cur_tag       = '0;
         cur_length    = '0;
         cur_skip      = '0;
         cur_tag_ok    = 1'b1;
         cur_fmt_seen  = 1'b0;
         cur_format    = '0;
         cur_channels  = '0;
         cur_rate      = '0;
         cur_depth     = '0;
         cur_remaining = '0;
      end else begin
         cur_phase     = phase_ff;
         cur_index     = byte_index_ff;
         cur_tag       = chunk_tag_ff;
         cur_length    = chunk_length_ff;
         cur_skip      = skip_count_ff;
         cur_tag_ok    = tag_ok_ff;
         cur_fmt_seen  = fmt_seen_ff;
         cur_format    = format_tag_ff;
         cur_channels  = channel_count_ff;
         cur_rate      = rate_value_ff;
         cur_depth     = depth_value_ff;
         cur_remaining = remaining_ff;
      end
   end

   assign pos = cur_index[1:0];

   always_comb begin
      phase_in         = cur_phase;
      byte_index_in    = cur_index;
      chunk_tag_in     = cur_tag;
      chunk_length_in  = cur_length;
      skip_count_in    = cur_skip;
      tag_ok_in        = cur_tag_ok;
      fmt_seen_in      = cur_fmt_seen;
      format_tag_in    = cur_format;
      channel_count_in = cur_channels;
      rate_value_in    = cur_rate;
      depth_value_in   = cur_depth;
      remaining_in     = cur_remaining;
      end_check        = 1'b1;
      hdr_emit         = 1'b0;
      hdr_status       = wavp_pkg::ST_OK;
      hdr_dsize        = '0;
      hdr_final        = 1'b0;
      pay_emit         = 1'b0;
      pay_final        = 1'b0;

      if (req_abort) begin
         phase_in  = wavp_pkg::PH_DONE;
         end_check = 1'b0;
      end else begin
         case (cur_phase)
            wavp_pkg::PH_RIFF: begin
               if (cur_index < 4'd4) begin
                  tag_ok_in = cur_tag_ok && (b == wavp_pkg::tag_char(wavp_pkg::TAG_RIFF, pos));
               end else if (cur_index >= 4'd8 && cur_index < 4'd12) begin
                  tag_ok_in = cur_tag_ok && (b == wavp_pkg::tag_char(wavp_pkg::TAG_WAVE, pos));
               end
               if (cur_index >= 4'd11) begin
                  byte_index_in = '0;
                  if (!tag_ok_in) begin
                     hdr_emit   = 1'b1;
                     hdr_status = wavp_pkg::ST_BAD_TAG;
                     hdr_final  = 1'b1;
                     phase_in   = wavp_pkg::PH_DONE;
                     end_check  = 1'b0;
                  end else begin
                     phase_in = wavp_pkg::PH_HDR;
                  end
               end else begin
                  byte_index_in = cur_index + 4'd1;
               end
            end
            wavp_pkg::PH_HDR: begin
               if (cur_index < 4'd4) begin
                  chunk_tag_in = {cur_tag[23:0], b};
                  if (cur_index == 4'd0) begin
                     chunk_length_in = '0;
                  end
               end else begin
                  chunk_length_in = wavp_pkg::put_byte(cur_length, pos, b);
               end
               if (cur_index < 4'd7) begin
                  byte_index_in = cur_index + 4'd1;
               end else begin
                  byte_index_in = '0;
                  if (chunk_tag_in == wavp_pkg::TAG_FMT) begin
                     if (chunk_length_in < wavp_pkg::FMT_BODY_LEN) begin
                        hdr_emit   = 1'b1;
                        hdr_status = wavp_pkg::ST_SHORT;
                        hdr_final  = 1'b1;
                        phase_in   = wavp_pkg::PH_DONE;
                        end_check  = 1'b0;
                     end else begin
                        phase_in = wavp_pkg::PH_FMT;
                     end
                  end else if (chunk_tag_in == wavp_pkg::TAG_DATA) begin
                     if (!cur_fmt_seen) begin
                        hdr_status = wavp_pkg::ST_NO_FMT;
                     end else if (cur_format != wavp_pkg::PCM_FORMAT
                                  || cur_depth != wavp_pkg::PCM_BITS
                                  || (cur_channels != 16'd1 && cur_channels != 16'd2)) begin
                        hdr_status = wavp_pkg::ST_UNSUPPORTED;
                     end
                     hdr_emit  = 1'b1;
                     hdr_dsize = chunk_length_in;
                     hdr_final = (hdr_status != wavp_pkg::ST_OK) || (chunk_length_in == '0)
                                 || req_last_of_file;
                     end_check = 1'b0;
                     if (hdr_final) begin
                        phase_in = wavp_pkg::PH_DONE;
                     end else begin
                        phase_in     = wavp_pkg::PH_PAY;
                        remaining_in = chunk_length_in;
                     end
                  end else begin
                     skip_count_in = {1'b0, chunk_length_in} + {32'h0, chunk_length_in[0]};
                     phase_in      = (skip_count_in != '0) ? wavp_pkg::PH_SKIP
                                                           : wavp_pkg::PH_HDR;
                  end
               end
            end
            wavp_pkg::PH_FMT: begin
               if (cur_index < 4'd2) begin
                  format_tag_in = 16'(wavp_pkg::put_byte({16'h0, cur_format},
                                                         {1'b0, cur_index[0]}, b));
               end else if (cur_index < 4'd4) begin
                  channel_count_in = 16'(wavp_pkg::put_byte({16'h0, cur_channels},
                                                            {1'b0, cur_index[0]}, b));
               end else if (cur_index < 4'd8) begin
                  rate_value_in = wavp_pkg::put_byte(cur_rate, pos, b);
               end else if (cur_index >= 4'd14) begin
                  depth_value_in = 16'(wavp_pkg::put_byte({16'h0, cur_depth},
                                                          {1'b0, cur_index[0]}, b));
               end
               if (cur_index < 4'd15) begin
                  byte_index_in = cur_index + 4'd1;
               end else begin
                  // skip whatever follows the 16 bytes we parse, plus the pad byte
                  byte_index_in = '0;
                  fmt_seen_in   = 1'b1;
                  skip_count_in = {1'b0, cur_length - wavp_pkg::FMT_BODY_LEN}
                                  + {32'h0, cur_length[0]};
                  phase_in      = (skip_count_in != '0) ? wavp_pkg::PH_SKIP
                                                        : wavp_pkg::PH_HDR;
               end
            end
            wavp_pkg::PH_SKIP: begin
               skip_count_in = cur_skip - 33'd1;
               if (skip_count_in == '0) begin
                  phase_in      = wavp_pkg::PH_HDR;
                  byte_index_in = '0;
               end
            end
            wavp_pkg::PH_PAY: begin
               remaining_in = cur_remaining - 32'd1;
               pay_emit     = 1'b1;
               pay_final    = (remaining_in == '0) || req_last_of_file;
               end_check    = 1'b0;
               if (pay_final) begin
                  phase_in = wavp_pkg::PH_DONE;
               end
            end
            default: begin
               phase_in  = wavp_pkg::PH_DONE;
               end_check = 1'b0;
            end
         endcase

         // file ended while still inside the header area
         if (end_check && req_last_of_file) begin
            hdr_emit   = 1'b1;
            hdr_status = (phase_in == wavp_pkg::PH_RIFF || phase_in == wavp_pkg::PH_FMT)
                         ? wavp_pkg::ST_SHORT : wavp_pkg::ST_NO_DATA;
            hdr_final  = 1'b1;
            phase_in   = wavp_pkg::PH_DONE;
         end
      end
   end

   assign res_valid = hdr_emit || pay_emit;

   always_comb begin
      is_payload_in   = pay_emit;
      status_in       = pay_emit ? wavp_pkg::ST_OK : hdr_status;
      format_code_in  = pay_emit ? 16'h0 : format_tag_in;
      channels_in     = pay_emit ? 16'h0 : channel_count_in;
      sample_hz_in    = pay_emit ? 32'h0 : rate_value_in;
      bits_in         = pay_emit ? 16'h0 : depth_value_in;
      chunk_bytes_in  = pay_emit ? 32'h0 : hdr_dsize;
      payload_byte_in = pay_emit ? b : 8'h0;
      final_in        = pay_emit ? pay_final : hdr_final;
   end

   always_comb begin
      if (req_fire) begin
         rsp_valid_in = res_valid;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= wavp_pkg::PH_RIFF;
         byte_index_ff    <= '0;
         chunk_tag_ff     <= '0;
         chunk_length_ff  <= '0;
         skip_count_ff    <= '0;
         tag_ok_ff        <= 1'b1;
         fmt_seen_ff      <= 1'b0;
         format_tag_ff    <= '0;
         channel_count_ff <= '0;
         rate_value_ff    <= '0;
         depth_value_ff   <= '0;
         remaining_ff     <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            phase_ff         <= phase_in;
            byte_index_ff    <= byte_index_in;
            chunk_tag_ff     <= chunk_tag_in;
            chunk_length_ff  <= chunk_length_in;
            skip_count_ff    <= skip_count_in;
            tag_ok_ff        <= tag_ok_in;
            fmt_seen_ff      <= fmt_seen_in;
            format_tag_ff    <= format_tag_in;
            channel_count_ff <= channel_count_in;
            rate_value_ff    <= rate_value_in;
            depth_value_ff   <= depth_value_in;
            remaining_ff     <= remaining_in;
         end
      end
   end

   // result payload: load on a producing item, hold otherwise
   always_ff @(posedge clock) begin
      if (req_fire && res_valid) begin
         is_payload_ff   <= is_payload_in;
         status_ff       <= status_in;
         format_code_ff  <= format_code_in;
         channels_ff     <= channels_in;
         sample_hz_ff    <= sample_hz_in;
         bits_ff         <= bits_in;
         chunk_bytes_ff  <= chunk_bytes_in;
         payload_byte_ff <= payload_byte_in;
         final_ff        <= final_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_is_payload   = is_payload_ff;
   assign rsp_status       = status_ff;
   assign rsp_format_code  = format_code_ff;
   assign rsp_channels     = channels_ff;
   assign rsp_sample_hz    = sample_hz_ff;
   assign rsp_sample_bits  = bits_ff;
   assign rsp_chunk_bytes  = chunk_bytes_ff;
   assign rsp_payload_byte = payload_byte_ff;
   assign rsp_final_res    = final_ff;

   `WAVP_ASSERT(a_error_is_final, rsp_valid && !rsp_is_payload && rsp_status != wavp_pkg::ST_OK |-> rsp_final_res)
   `WAVP_ASSERT(a_payload_ok, rsp_valid && rsp_is_payload |-> rsp_status == wavp_pkg::ST_OK)
   `WAVP_ASSERT_NEXT(a_abort_done, req_valid && req_ready && req_abort, phase_ff == wavp_pkg::PH_DONE)
   `WAVP_ASSERT_NEXT(a_final_done, req_valid && req_ready && res_valid && final_in, phase_ff == wavp_pkg::PH_DONE)

endmodule

`default_nettype wire
